/* rtl/core/adpcm_pkg.sv */
// Package for the ADPCM block decoder: widths, status codes, command struct,
// and the MS / IMA coefficient tables. No dependencies.
package adpcm_pkg;

    localparam int MAX_BLOCK_BYTES = 8192;
    localparam int IMA_CHUNK_SAMPLES = 8;
    localparam int POS_W = 14;

    localparam logic [1:0] ST_SAMPLE   = 2'd0;
    localparam logic [1:0] ST_BAD_PRED = 2'd1;
    localparam logic [1:0] ST_BAD_SYNC = 2'd2;
    localparam logic [1:0] ST_BAD_SIZE = 2'd3;

    localparam logic [1:0] CFG_LAYOUT   = 2'd0;
    localparam logic [1:0] CFG_CHANNELS = 2'd1;
    localparam logic [1:0] CFG_BLOCK    = 2'd2;

    // datapath operations, one per cycle while the result register is not busy
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_BYTE   = 3'd1;  // header handling of the byte
    localparam logic [2:0] OP_NIB    = 3'd2;  // decode one nibble into slot
    localparam logic [2:0] OP_EMIT   = 3'd3;  // push one result

    typedef struct packed {
        logic [2:0]  op;
        logic        ch;       // channel for nibble / emit
        logic [3:0]  code;     // nibble
        logic [1:0]  src;      // emit source: 0 newest,1 older,2 slot,3 left buffer
        logic        slot;     // nibble slot
        logic [2:0]  lidx;     // left buffer index
        logic        lwrite;   // store nibble result into left buffer
        logic [1:0]  status;
        logic        last_run;
        logic        last_blk;
    } cmd_t;

    function automatic logic signed [10:0] ms_adapt(input logic [3:0] c);
        case (c)
            4'd4, 4'd12: ms_adapt = 11'sd307;
            4'd5, 4'd11: ms_adapt = 11'sd409;
            4'd6, 4'd10: ms_adapt = 11'sd512;
            4'd7, 4'd9:  ms_adapt = 11'sd614;
            4'd8:        ms_adapt = 11'sd768;
            default:     ms_adapt = 11'sd230;
        endcase
    endfunction

    function automatic logic signed [10:0] ms_coef1(input logic [2:0] s);
        case (s)
            3'd0: ms_coef1 = 11'sd256;
            3'd1: ms_coef1 = 11'sd512;
            3'd3: ms_coef1 = 11'sd192;
            3'd4: ms_coef1 = 11'sd240;
            3'd5: ms_coef1 = 11'sd460;
            3'd6: ms_coef1 = 11'sd392;
            default: ms_coef1 = 11'sd0;
        endcase
    endfunction

    function automatic logic signed [10:0] ms_coef2(input logic [2:0] s);
        case (s)
            3'd1: ms_coef2 = -11'sd256;
            3'd3: ms_coef2 = 11'sd64;
            3'd5: ms_coef2 = -11'sd208;
            3'd6: ms_coef2 = -11'sd232;
            default: ms_coef2 = 11'sd0;
        endcase
    endfunction

    function automatic logic signed [4:0] ima_adjust(input logic [3:0] c);
        case (c[2:0])
            3'd4: ima_adjust = 5'sd2;
            3'd5: ima_adjust = 5'sd4;
            3'd6: ima_adjust = 5'sd6;
            3'd7: ima_adjust = 5'sd8;
            default: ima_adjust = -5'sd1;
        endcase
    endfunction

    function automatic logic [14:0] ima_step(input logic [6:0] i);
        logic [14:0] t [0:88];
        t = '{15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16,
              15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37,
              15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88,
              15'd97, 15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190,
              15'd209, 15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408,
              15'd449, 15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876,
              15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707,
              15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327,
              15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
              15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
              15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
              15'd24623, 15'd27086, 15'd29794, 15'd32767};
        if (i > 7'd88) ima_step = 15'd32767;
        else ima_step = t[i];
    endfunction

endpackage

/* rtl/core/adpcm_block_decoder.sv */
// ADPCM block decoder (MS ADPCM and IMA/DVI ADPCM WAV blocks), top level.
// Path: each byte is registered in the controller; an error beat then goes straight
// to the result register, a sample via channel state (MS, headers) or slot/left buffer (IMA).
// Sequencing: a byte is accepted only while idle, then takes one step per nibble
// decode and per result beat (none if skipped); result beats wait on a held output.
// Reset: synchronous active-low aresetn clears control and channel state; MS, mono, 256.
module adpcm_block_decoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [13:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_pcm_sample,
    output logic                 m_channel,
    output logic [1:0]           m_status,
    output logic                 m_last_of_run,
    output logic                 m_last_of_block
);
    import adpcm_pkg::*;

    logic        layout_reg;
    logic [1:0]  channels_reg;
    logic [13:0] block_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg <= 1'b0;
            channels_reg <= 2'd1;
            block_reg <= 14'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LAYOUT:   layout_reg <= cfg_data[0];
                CFG_CHANNELS: channels_reg <= cfg_data[1:0];
                CFG_BLOCK:    block_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cmd_t        cmd;
    logic [7:0]  cmd_byte;
    logic [13:0] cmd_pos;
    logic        emit_busy;

    adpcm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_layout(layout_reg), .cfg_channels(channels_reg), .cfg_block(block_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .cmd(cmd), .cmd_byte(cmd_byte), .cmd_pos(cmd_pos), .emit_busy(emit_busy)
    );

    adpcm_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_layout(layout_reg), .cfg_channels(channels_reg),
        .cmd(cmd), .cmd_byte(cmd_byte), .cmd_pos(cmd_pos), .emit_busy(emit_busy),
        .m_valid(m_valid), .m_ready(m_ready), .m_pcm_sample(m_pcm_sample),
        .m_channel(m_channel), .m_status(m_status),
        .m_last_of_run(m_last_of_run), .m_last_of_block(m_last_of_block)
    );

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_SAMPLE |-> m_pcm_sample == 16'sd0 && m_last_of_block)
        else $error("error beat carries data");
    a_err_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_SAMPLE |-> !m_channel && m_last_of_run)
        else $error("error beat channel");
    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped");
endmodule

/* rtl/core/adpcm_ctrl.sv */
// Controller for the ADPCM block decoder: byte framing, size check and the
// per-byte command sequence. Depends on adpcm_pkg.
module adpcm_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_layout,
    input  logic [1:0]           cfg_channels,
    input  logic [13:0]          cfg_block,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    output adpcm_pkg::cmd_t      cmd,
    output logic [7:0]           cmd_byte,
    output logic [13:0]          cmd_pos,
    input  logic                 emit_busy
);
    import adpcm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;

    logic [1:0]  state_reg, state_next;
    logic [13:0] pos_reg, pos_next;
    logic        skip_reg, skip_next;
    logic [7:0]  byte_reg;
    logic [13:0] bpos_reg;
    logic        ends_reg;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  nsteps_reg;
    logic [4:0]  kind_reg;  // sequence selector
    logic [2:0]  kbase_reg;

    logic [13:0] len;
    logic        usable;
    logic [13:0] rem_ima;
    logic [13:0] hdr_ms, hdr_ima;
    logic        stereo;
    logic        hdr_err_set;
    logic        is_err_byte;

    assign stereo = (cfg_channels == 2'd2);
    assign hdr_ms  = stereo ? 14'd14 : 14'd7;
    assign hdr_ima = stereo ? 14'd8 : 14'd4;
    assign len = (cfg_block == 14'd0) ? 14'd1 :
                 (cfg_block > 14'(MAX_BLOCK_BYTES) ? 14'(MAX_BLOCK_BYTES) : cfg_block);
    assign rem_ima = cfg_block - hdr_ima;

    always_comb begin
        usable = 1'b1;
        if (cfg_channels != 2'd1 && cfg_channels != 2'd2) usable = 1'b0;
        else if (cfg_block > 14'(MAX_BLOCK_BYTES)) usable = 1'b0;
        else if (!cfg_layout) usable = (cfg_block >= hdr_ms);
        else if (cfg_block < hdr_ima) usable = 1'b0;
        else usable = stereo ? (rem_ima[2:0] == 3'd0) : (rem_ima[1:0] == 2'd0);
    end

    // sequence kinds
    localparam logic [4:0] K_NONE    = 5'd0;
    localparam logic [4:0] K_ERR     = 5'd1;  // size error
    localparam logic [4:0] K_HDR     = 5'd2;  // header byte, datapath decides
    localparam logic [4:0] K_MS_EMIT = 5'd3;  // last MS header byte
    localparam logic [4:0] K_IMA_EMIT= 5'd4;  // last IMA header byte
    localparam logic [4:0] K_MS_DATA = 5'd5;
    localparam logic [4:0] K_IMA_M   = 5'd6;
    localparam logic [4:0] K_IMA_L   = 5'd7;
    localparam logic [4:0] K_IMA_R   = 5'd8;

    logic [4:0] kind_sel;
    logic [3:0] nsteps_sel;
    logic [13:0] dpos;

    always_comb begin
        dpos = pos_reg - (cfg_layout ? hdr_ima : hdr_ms);
        kind_sel = K_NONE;
        nsteps_sel = 4'd0;
        if (skip_reg) begin
            kind_sel = K_NONE;
        end else if (!usable) begin
            kind_sel = K_ERR; nsteps_sel = 4'd1;
        end else if (!cfg_layout) begin
            if (pos_reg == hdr_ms - 14'd1) begin
                kind_sel = K_MS_EMIT; nsteps_sel = stereo ? 4'd5 : 4'd3;
            end else if (pos_reg < hdr_ms) begin
                kind_sel = K_HDR; nsteps_sel = 4'd1;
            end else begin
                kind_sel = K_MS_DATA; nsteps_sel = 4'd4;
            end
        end else begin
            if (pos_reg == hdr_ima - 14'd1) begin
                kind_sel = K_IMA_EMIT; nsteps_sel = stereo ? 4'd3 : 4'd2;
            end else if (pos_reg < hdr_ima) begin
                kind_sel = K_HDR; nsteps_sel = 4'd1;
            end else if (!stereo) begin
                kind_sel = K_IMA_M; nsteps_sel = 4'd4;
            end else if (!dpos[2]) begin
                kind_sel = K_IMA_L; nsteps_sel = 4'd2;
            end else begin
                kind_sel = K_IMA_R; nsteps_sel = 4'd6;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        skip_next = skip_reg;
        step_next = step_reg;
        if (state_reg == S_IDLE) begin
            if (s_valid) begin
                pos_next = (pos_reg + 14'd1 >= len) ? 14'd0 : pos_reg + 14'd1;
                if (kind_sel != K_NONE) begin
                    state_next = S_RUN;
                    step_next = 4'd0;
                end
                if (pos_reg + 14'd1 >= len) skip_next = 1'b0;
                else if (kind_sel == K_ERR) skip_next = 1'b1;
            end
        end else if (!emit_busy) begin
            step_next = step_reg + 4'd1;
            // drop the rest of the sequence after a header error beat
            if (step_reg + 4'd1 == nsteps_reg || is_err_byte) state_next = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            pos_reg <= '0;
            skip_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            step_reg <= step_next;
            // skip is also set by a predictor / sync header error, detected below
            skip_reg <= skip_next | hdr_err_set;
        end
        if (state_reg == S_IDLE && s_valid) begin
            byte_reg <= s_data_byte;
            bpos_reg <= pos_reg;
            ends_reg <= (pos_reg + 14'd1 >= len);
            kind_reg <= kind_sel;
            nsteps_reg <= nsteps_sel;
            kbase_reg <= {dpos[1:0], 1'b0};
        end
    end

    // header error detection (predictor or sync) sets skip unless block ends
    always_comb begin
        is_err_byte = 1'b0;
        if (state_reg == S_RUN && step_reg == 4'd0) begin
            if ((kind_reg == K_HDR || kind_reg == K_MS_EMIT || kind_reg == K_IMA_EMIT)) begin
                if (!cfg_layout)
                    is_err_byte = (bpos_reg < (stereo ? 14'd2 : 14'd1)) && byte_reg > 8'd6;
                else
                    is_err_byte = (bpos_reg[1:0] == 2'd3) && byte_reg != 8'd0;
            end
        end
        hdr_err_set = is_err_byte && !ends_reg && !emit_busy;
    end

    assign cmd_byte = byte_reg;
    assign cmd_pos = bpos_reg;

    always_comb begin
        logic last;
        last = (step_reg + 4'd1 == nsteps_reg);
        cmd = '0;
        cmd.last_run = last;
        cmd.last_blk = last && ends_reg;
        if (state_reg == S_RUN) begin
            case (kind_reg)
                K_ERR: begin
                    cmd.op = OP_EMIT; cmd.src = 2'd2; cmd.status = ST_BAD_SIZE;
                    cmd.last_blk = 1'b1;
                end
                K_HDR: begin
                    cmd.op = OP_BYTE;
                end
                K_MS_EMIT: begin
                    if (step_reg == 4'd0) cmd.op = OP_BYTE;
                    else begin
                        cmd.op = OP_EMIT;
                        cmd.src = (step_reg <= (stereo ? 4'd2 : 4'd1)) ? 2'd1 : 2'd0;
                        cmd.ch = stereo ? ~step_reg[0] : 1'b0;
                    end
                end
                K_IMA_EMIT: begin
                    if (step_reg == 4'd0) cmd.op = OP_BYTE;
                    else begin
                        cmd.op = OP_EMIT; cmd.src = 2'd0;
                        cmd.ch = stereo ? ~step_reg[0] : 1'b0;
                    end
                end
                K_MS_DATA: begin
                    case (step_reg)
                        4'd0: begin cmd.op = OP_NIB; cmd.ch = 1'b0;
                            cmd.code = byte_reg[7:4]; end
                        4'd1: begin cmd.op = OP_EMIT; cmd.src = 2'd0; cmd.ch = 1'b0; end
                        4'd2: begin cmd.op = OP_NIB; cmd.ch = stereo;
                            cmd.code = byte_reg[3:0]; end
                        default: begin cmd.op = OP_EMIT; cmd.src = 2'd0; cmd.ch = stereo; end
                    endcase
                end
                K_IMA_M: begin
                    case (step_reg)
                        4'd0: begin cmd.op = OP_NIB; cmd.code = byte_reg[3:0];
                            cmd.slot = 1'b0; end
                        4'd1: begin cmd.op = OP_NIB; cmd.code = byte_reg[7:4];
                            cmd.slot = 1'b1; end
                        4'd2: begin cmd.op = OP_EMIT; cmd.src = 2'd2; cmd.slot = 1'b0; end
                        default: begin cmd.op = OP_EMIT; cmd.src = 2'd2; cmd.slot = 1'b1; end
                    endcase
                end
                K_IMA_L: begin
                    cmd.op = OP_NIB; cmd.lwrite = 1'b1;
                    cmd.code = step_reg[0] ? byte_reg[7:4] : byte_reg[3:0];
                    cmd.lidx = kbase_reg | {2'b00, step_reg[0]};
                end
                K_IMA_R: begin
                    cmd.ch = 1'b1;
                    case (step_reg)
                        4'd0: begin cmd.op = OP_NIB; cmd.code = byte_reg[3:0];
                            cmd.slot = 1'b0; end
                        4'd1: begin cmd.op = OP_NIB; cmd.code = byte_reg[7:4];
                            cmd.slot = 1'b1; end
                        4'd2: begin cmd.op = OP_EMIT; cmd.src = 2'd3; cmd.ch = 1'b0;
                            cmd.lidx = kbase_reg; end
                        4'd3: begin cmd.op = OP_EMIT; cmd.src = 2'd2; cmd.slot = 1'b0; end
                        4'd4: begin cmd.op = OP_EMIT; cmd.src = 2'd3; cmd.ch = 1'b0;
                            cmd.lidx = kbase_reg | 3'd1; end
                        default: begin cmd.op = OP_EMIT; cmd.src = 2'd2; cmd.slot = 1'b1; end
                    endcase
                end
                default: cmd.op = OP_NONE;
            endcase
        end
    end
endmodule

/* rtl/core/adpcm_dp.sv */
// Datapath for the ADPCM block decoder: channel state, nibble decoders, left
// chunk buffer and the result register. Depends on adpcm_pkg.
module adpcm_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_layout,
    input  logic [1:0]           cfg_channels,
    input  adpcm_pkg::cmd_t      cmd,
    input  logic [7:0]           cmd_byte,
    input  logic [13:0]          cmd_pos,
    output logic                 emit_busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_pcm_sample,
    output logic                 m_channel,
    output logic [1:0]           m_status,
    output logic                 m_last_of_run,
    output logic                 m_last_of_block
);
    import adpcm_pkg::*;

    logic [7:0]         pend_reg;
    logic [2:0]         pred_reg   [0:1];
    logic signed [15:0] delta_reg  [0:1];
    logic signed [15:0] newest_reg [0:1];
    logic signed [15:0] older_reg  [0:1];
    logic [6:0]         sidx_reg   [0:1];
    logic signed [15:0] slot_reg   [0:1];
    logic signed [15:0] left_mem   [0:7];
    logic               stereo;
    logic               header_err;
    logic [13:0]        r;
    logic [13:0]        chn;
    assign stereo = (cfg_channels == 2'd2);

    // output register busy: a new result only when the slot is free or drains
    logic out_free;
    assign out_free = !m_valid || m_ready;
    assign emit_busy = (cmd.op == OP_EMIT || header_err) && !out_free;

    // ---------- header byte decoding ----------
    always_comb begin
        chn = stereo ? 14'd2 : 14'd1;
        r = cmd_pos - chn;
        header_err = 1'b0;
        if (cmd.op == OP_BYTE) begin
            if (!cfg_layout) header_err = (cmd_pos < chn) && cmd_byte > 8'd6;
            else header_err = (cmd_pos[1:0] == 2'd3) && cmd_byte != 8'd0;
        end
    end

    // ---------- nibble decoders ----------
    logic signed [15:0] d_cur, ms_cur, ima_cur;
    logic signed [15:0] ms_nd;
    logic [6:0]         ima_ni;
    always_comb begin
        logic [2:0] sel;
        logic signed [26:0] dp;
        logic signed [27:0] pr;
        logic signed [19:0] sdel;
        logic signed [28:0] tot;
        logic signed [26:0] prd;
        logic [6:0] si;
        logic [14:0] st;
        logic [17:0] diff;
        logic signed [18:0] sum;
        logic signed [7:0] ni;
        sel = (pred_reg[cmd.ch] > 3'd6) ? 3'd0 : pred_reg[cmd.ch];
        dp = ms_adapt(cmd.code) * delta_reg[cmd.ch];
        ms_nd = 16'(dp >>> 8);
        if (ms_nd < 16'sd16) ms_nd = 16'sd16;
        pr = newest_reg[cmd.ch] * ms_coef1(sel) + older_reg[cmd.ch] * ms_coef2(sel);
        prd = 27'(pr >>> 8);
        sdel = $signed(cmd.code) * delta_reg[cmd.ch];
        tot = 29'(sdel) + 29'(prd);
        if (tot > 29'sd32767) ms_cur = 16'sd32767;
        else if (tot < -29'sd32768) ms_cur = -16'sd32768;
        else ms_cur = 16'(tot);

        si = (sidx_reg[cmd.ch] > 7'd88) ? 7'd88 : sidx_reg[cmd.ch];
        st = ima_step(si);
        diff = 18'(({16'd0, cmd.code[2:0]} * 19'(st) * 19'd2 + 19'(st)) >> 3);
        if (cmd.code[3]) sum = 19'(newest_reg[cmd.ch]) - 19'(diff);
        else sum = 19'(newest_reg[cmd.ch]) + 19'(diff);
        if (sum > 19'sd32767) ima_cur = 16'sd32767;
        else if (sum < -19'sd32768) ima_cur = -16'sd32768;
        else ima_cur = 16'(sum);
        ni = 8'(si) + 8'(ima_adjust(cmd.code));
        ima_ni = (ni < 0) ? 7'd0 : ((ni > 8'sd88) ? 7'd88 : 7'(ni));
        d_cur = cfg_layout ? ima_cur : ms_cur;
    end

    // ---------- state update ----------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            for (int i = 0; i < 2; i++) begin
                pred_reg[i] <= '0; delta_reg[i] <= '0; newest_reg[i] <= '0;
                older_reg[i] <= '0; sidx_reg[i] <= '0;
            end
        end else begin
            if (cmd.op == OP_BYTE && !header_err) begin
                if (!cfg_layout) begin
                    if (cmd_pos < chn) pred_reg[cmd_pos[0]] <= cmd_byte[2:0];
                    else if (!r[0]) pend_reg <= cmd_byte;
                    else begin
                        logic c;
                        logic [13:0] f;
                        c = stereo ? r[1] : 1'b0;
                        f = stereo ? (r >> 2) : (r >> 1);
                        if (f == 14'd0) delta_reg[c] <= {cmd_byte, pend_reg};
                        else if (f == 14'd1) newest_reg[c] <= {cmd_byte, pend_reg};
                        else older_reg[c] <= {cmd_byte, pend_reg};
                    end
                end else begin
                    case (cmd_pos[1:0])
                        2'd0: pend_reg <= cmd_byte;
                        2'd1: newest_reg[cmd_pos[2]] <= {cmd_byte, pend_reg};
                        2'd2: sidx_reg[cmd_pos[2]] <=
                            (cmd_byte > 8'd88) ? 7'd88 : cmd_byte[6:0];
                        default: ;
                    endcase
                end
            end
            if (cmd.op == OP_NIB) begin
                if (!cfg_layout) begin
                    delta_reg[cmd.ch] <= ms_nd;
                    older_reg[cmd.ch] <= newest_reg[cmd.ch];
                    newest_reg[cmd.ch] <= ms_cur;
                end else begin
                    newest_reg[cmd.ch] <= ima_cur;
                    sidx_reg[cmd.ch] <= ima_ni;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_NIB) begin
            slot_reg[cmd.slot] <= d_cur;
            if (cmd.lwrite) left_mem[cmd.lidx] <= d_cur;
        end
    end

    // ---------- result register ----------
    logic signed [15:0] esample;
    always_comb begin
        case (cmd.src)
            2'd0: esample = newest_reg[cmd.ch];
            2'd1: esample = older_reg[cmd.ch];
            2'd2: esample = (cmd.status != ST_SAMPLE) ? 16'sd0 : slot_reg[cmd.slot];
            default: esample = left_mem[cmd.lidx];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= (cmd.op == OP_EMIT) || header_err;
        end
        if (out_free) begin
            if (header_err) begin
                m_pcm_sample <= '0; m_channel <= 1'b0;
                m_status <= cfg_layout ? ST_BAD_SYNC : ST_BAD_PRED;
                m_last_of_run <= 1'b1; m_last_of_block <= 1'b1;
            end else begin
                m_pcm_sample <= esample;
                m_channel <= (cmd.status != ST_SAMPLE) ? 1'b0 : cmd.ch;
                m_status <= cmd.status;
                m_last_of_run <= cmd.last_run;
                m_last_of_block <= cmd.last_blk;
            end
        end
    end
endmodule
